// File: rtl/ttcb_pkg.sv
// ----------------------------------------------------------------------------
// ttcb_pkg
// Types and constants shared by the text terminal cell buffer: operation
// codes, controller states, command and status groups.
// ----------------------------------------------------------------------------
package ttcb_pkg;

    localparam int KIND_W  = 3;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'd7;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT    = 3'd0,
        KIND_WCELL  = 3'd1,
        KIND_WCHAR  = 3'd2,
        KIND_WATTR  = 3'd3,
        KIND_RATTR  = 3'd4,
        KIND_SETCUR = 3'd5,
        KIND_CLEAR  = 3'd6,
        KIND_FILL   = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_BLANK,
        ST_SWEEP,
        ST_PUT_WR,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MEM_NONE,
        MEM_ITEM,
        MEM_PUT,
        MEM_INIT,
        MEM_CLEAR,
        MEM_FILL,
        MEM_SCR_RD,
        MEM_SCR_WR,
        MEM_BLANK
    } mem_op_t;

    typedef enum logic [2:0] {
        CUR_NONE,
        CUR_NEWLINE,
        CUR_ADV,
        CUR_SET,
        CUR_HOME
    } cur_op_t;

    typedef struct packed {
        logic    take;
        mem_op_t mem_op;
        cur_op_t cur_op;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  req_valid;
        logic  newline;
        logic  wrap_pend;
        logic  last_row;
        logic  last_cell;
        logic  last_scroll;
        logic  last_col;
        logic  out_free;
    } ctrl_sts_t;

endpackage

// File: rtl/ttcb_if.sv
// ----------------------------------------------------------------------------
// ttcb interfaces
// Request, response and configuration channels of the cell buffer, each with
// a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttcb_req_if;
    import ttcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] attribute;

    modport source (output valid, kind, row, col, char_code, attribute, input ready);
    modport sink   (input valid, kind, row, col, char_code, attribute, output ready);
endinterface

interface ttcb_rsp_if;
    import ttcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] attr_value;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;

    modport source (output valid, attr_value, cursor_row, cursor_col, input ready);
    modport sink   (input valid, attr_value, cursor_row, cursor_col, output ready);
endinterface

interface ttcb_cfg_if;
    import ttcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: rtl/ttcb_ctrl.sv
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Sequencer of the cell buffer: takes a word, runs the single-cell access or
// the scroll, clear and fill sweeps, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module ttcb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  ttcb_pkg::ctrl_sts_t sts,
    output ttcb_pkg::ctrl_cmd_t cmd
);
    import ttcb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.take     = 1'b0;
        cmd.mem_op   = MEM_NONE;
        cmd.cur_op   = CUR_NONE;
        cmd.cnt_clr  = 1'b0;
        cmd.cnt_inc  = 1'b0;
        cmd.out_load = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                cmd.mem_op  = MEM_INIT;
                cmd.cnt_inc = 1'b1;
                if (sts.last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                cmd.take = 1'b1;
                if (sts.req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                cmd.cnt_clr = 1'b1;
                state_next  = ST_DONE;
                unique case (sts.kind)
                    KIND_PUT:
                    begin
                        if (sts.newline || sts.wrap_pend)
                        begin
                            cmd.cur_op = CUR_NEWLINE;
                            if (sts.last_row)
                            begin
                                state_next = ST_SCROLL_RD;
                            end
                            else if (!sts.newline)
                            begin
                                state_next = ST_PUT_WR;
                            end
                        end
                        else
                        begin
                            cmd.mem_op = MEM_PUT;
                            cmd.cur_op = CUR_ADV;
                        end
                    end
                    KIND_WCELL, KIND_WCHAR, KIND_WATTR, KIND_RATTR:
                    begin
                        cmd.mem_op = MEM_ITEM;
                    end
                    KIND_SETCUR:
                    begin
                        cmd.cur_op = CUR_SET;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.cur_op = CUR_HOME;
                        state_next = ST_SWEEP;
                    end
                    KIND_FILL:
                    begin
                        state_next = ST_SWEEP;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_SCROLL_RD:
            begin
                cmd.mem_op = MEM_SCR_RD;
                state_next = ST_SCROLL_WR;
            end

            ST_SCROLL_WR:
            begin
                cmd.mem_op = MEM_SCR_WR;
                if (sts.last_scroll)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_BLANK;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_SCROLL_RD;
                end
            end

            ST_BLANK:
            begin
                cmd.mem_op  = MEM_BLANK;
                cmd.cnt_inc = 1'b1;
                if (sts.last_col)
                begin
                    // a wrapped put still owes its character to the new bottom row
                    state_next = sts.newline ? ST_DONE : ST_PUT_WR;
                end
            end

            ST_SWEEP:
            begin
                cmd.mem_op  = (sts.kind == KIND_CLEAR) ? MEM_CLEAR : MEM_FILL;
                cmd.cnt_inc = 1'b1;
                if (sts.last_cell)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_PUT_WR:
            begin
                cmd.mem_op = MEM_PUT;
                cmd.cur_op = CUR_ADV;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ttcb_datapath.sv
// ----------------------------------------------------------------------------
// ttcb_datapath
// Character and attribute memories, cursor, sweep counter, default attribute
// register and the output word register of the cell buffer.
// ----------------------------------------------------------------------------
module ttcb_datapath #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                clk,
    input  logic                rst_n,
    ttcb_req_if.sink            req,
    ttcb_rsp_if.source          rsp,
    ttcb_cfg_if.sink            cfg,
    input  ttcb_pkg::ctrl_cmd_t cmd,
    output ttcb_pkg::ctrl_sts_t sts
);
    import ttcb_pkg::*;

    localparam int CELLS        = ROWS * COLS;
    localparam int AW           = $clog2(CELLS);
    localparam int RW           = $clog2(ROWS);
    localparam int CW           = $clog2(COLS + 1);
    localparam int SCROLL_CELLS = (ROWS - 1) * COLS;

    // latched word
    kind_t             kind_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [BYTE_W-1:0] char_reg;
    logic [BYTE_W-1:0] attr_reg;

    logic [RW-1:0]     cur_row_reg;
    logic [RW-1:0]     cur_row_next;
    logic [CW-1:0]     cur_col_reg;
    logic [CW-1:0]     cur_col_next;
    logic [AW-1:0]     cnt_reg;
    logic [BYTE_W-1:0] default_attr_reg;

    logic [BYTE_W-1:0] char_mem [CELLS];
    logic [BYTE_W-1:0] attr_mem [CELLS];
    logic [BYTE_W-1:0] char_rd_reg;
    logic [BYTE_W-1:0] attr_rd_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_attr_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;

    logic              item_in_range;
    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     cur_addr;
    logic              last_row;
    logic              we_char;
    logic              we_attr;
    logic              re;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] wchar;
    logic [BYTE_W-1:0] wattr;

    assign item_in_range = (32'(row_reg) < ROWS) && (32'(col_reg) < COLS);
    assign item_addr     = AW'(32'(row_reg) * COLS + 32'(col_reg));
    assign cur_addr      = AW'(32'(cur_row_reg) * COLS + 32'(cur_col_reg));
    assign last_row      = (32'(cur_row_reg) == ROWS - 1);

    // ---- input word latch
    assign req.ready = cmd.take;

    always_ff @(posedge clk)
    begin
        if (cmd.take && req.valid)
        begin
            kind_reg <= kind_t'(req.kind);
            row_reg  <= req.row;
            col_reg  <= req.col;
            char_reg <= req.char_code;
            attr_reg <= req.attribute;
        end
    end

    // ---- configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= RESET_ATTR;
        end
        else if (cfg.valid)
        begin
            default_attr_reg <= cfg.data;
        end
    end

    // ---- sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + AW'(1);
        end
    end

    // ---- cursor
    always_comb
    begin
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        unique case (cmd.cur_op)
            CUR_NONE:
            begin
                cur_row_next = cur_row_reg;
            end
            CUR_NEWLINE:
            begin
                // on the last row the scroll keeps the cursor on that row
                cur_col_next = '0;
                if (!last_row)
                begin
                    cur_row_next = cur_row_reg + RW'(1);
                end
            end
            CUR_ADV:
            begin
                cur_col_next = cur_col_reg + CW'(1);
            end
            CUR_SET:
            begin
                cur_row_next = (32'(row_reg) >= ROWS) ? RW'(ROWS - 1) : RW'(row_reg);
                cur_col_next = (32'(col_reg) > COLS) ? CW'(COLS) : CW'(col_reg);
            end
            CUR_HOME:
            begin
                cur_row_next = '0;
                cur_col_next = '0;
            end
            default:
            begin
                cur_row_next = cur_row_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else
        begin
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
        end
    end

    // ---- memory port selection
    always_comb
    begin
        we_char = 1'b0;
        we_attr = 1'b0;
        re      = 1'b0;
        waddr   = cnt_reg;
        raddr   = item_addr;
        wchar   = SPACE_CODE;
        wattr   = default_attr_reg;
        unique case (cmd.mem_op)
            MEM_NONE:
            begin
                re = 1'b0;
            end
            MEM_ITEM:
            begin
                waddr = item_addr;
                wchar = char_reg;
                wattr = attr_reg;
                unique case (kind_reg)
                    KIND_WCELL:
                    begin
                        we_char = item_in_range;
                        we_attr = item_in_range;
                    end
                    KIND_WCHAR:
                    begin
                        we_char = item_in_range;
                    end
                    KIND_WATTR:
                    begin
                        we_attr = item_in_range;
                    end
                    KIND_RATTR:
                    begin
                        re = item_in_range;
                    end
                    default:
                    begin
                        re = 1'b0;
                    end
                endcase
            end
            MEM_PUT:
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                waddr   = cur_addr;
                wchar   = char_reg;
            end
            MEM_INIT:
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                wattr   = RESET_ATTR;
            end
            MEM_CLEAR:
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
            end
            MEM_FILL:
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                wchar   = char_reg;
                wattr   = attr_reg;
            end
            MEM_SCR_RD:
            begin
                re    = 1'b1;
                raddr = AW'(32'(cnt_reg) + COLS);
            end
            MEM_SCR_WR:
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                wchar   = char_rd_reg;
                wattr   = attr_rd_reg;
            end
            MEM_BLANK:
            begin
                we_char = 1'b1;
                we_attr = 1'b1;
                waddr   = AW'(32'(cnt_reg) + SCROLL_CELLS);
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_char)
        begin
            char_mem[waddr] <= wchar;
        end
        if (re)
        begin
            char_rd_reg <= char_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_attr)
        begin
            attr_mem[waddr] <= wattr;
        end
        if (re)
        begin
            attr_rd_reg <= attr_mem[raddr];
        end
    end

    // ---- output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_attr_reg <= (kind_reg == KIND_RATTR && item_in_range) ? attr_rd_reg : '0;
            out_row_reg  <= ROW_W'(cur_row_reg);
            out_col_reg  <= COL_W'(cur_col_reg);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.attr_value = out_attr_reg;
    assign rsp.cursor_row = out_row_reg;
    assign rsp.cursor_col = out_col_reg;

    // ---- status to the sequencer
    assign sts.kind        = kind_reg;
    assign sts.req_valid   = req.valid;
    assign sts.newline     = (char_reg == NEWLINE_CODE);
    assign sts.wrap_pend   = (32'(cur_col_reg) >= COLS);
    assign sts.last_row    = last_row;
    assign sts.last_cell   = (32'(cnt_reg) == CELLS - 1);
    assign sts.last_scroll = (32'(cnt_reg) == SCROLL_CELLS - 1);
    assign sts.last_col    = (32'(cnt_reg) == COLS - 1);
    assign sts.out_free    = !out_valid_reg || rsp.ready;

endmodule

// File: rtl/text_terminal_cell_buffer.sv
// A put or cell access is taken in the idle state and passes the execute and done states; a put
// that resolves a pending wrap also passes the put-write state. The done state loads the output
// word register once it is free, and the next word is taken back in idle. Clear and fill walk every cell.
// A scroll reads and writes each cell of rows 1 to ROWS-1 one row up, then blanks the bottom row.
// Reset (rst_n low, asynchronous) homes the cursor and sets the default attribute to 7;
// a sweep then blanks the screen before the first word is taken.
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer
// Text screen of character and attribute cells with a teletype cursor,
// scrolling, addressed cell access, clear and fill.
// ----------------------------------------------------------------------------
module text_terminal_cell_buffer #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    ttcb_req_if.sink   req,
    ttcb_rsp_if.source rsp,
    ttcb_cfg_if.sink   cfg
);
    import ttcb_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    ttcb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    ttcb_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
